FILE: rtl/periodic_task_scheduler_top_macros.svh
// Assertion helpers used by the scheduler controller (pts_ctrl).
`ifndef PERIODIC_TASK_SCHEDULER_TOP_MACROS_SVH
`define PERIODIC_TASK_SCHEDULER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define PTS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PTS_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PTS_ASSERT(name, prop, msg)
`define PTS_NEVER(name, cond, msg)
`endif

`endif

FILE: rtl/pts_pkg.sv
package pts_pkg;

  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 10;
  localparam int PERIOD_BITS    = 10;
  localparam int TICK_BITS      = 16;
  localparam int ID_BITS        = 2;
  localparam int IN_TDATA_BITS  = 8;
  localparam int OUT_TDATA_BITS = 24;
  localparam int NUM_CFG_TASKS  = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_POLICY  = 3'd0,
    REG_BURST0  = 3'd1,
    REG_BURST1  = 3'd2,
    REG_BURST2  = 3'd3,
    REG_PERIOD0 = 3'd4,
    REG_PERIOD1 = 3'd5,
    REG_PERIOD2 = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic start;       // word accepted this cycle
    logic scan;        // examine one task
    logic scan_first;  // first task of the scan
    logic commit;      // apply decision, step phases, emit result
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

FILE: rtl/pts_ctrl.sv
`include "periodic_task_scheduler_top_macros.svh"

module pts_ctrl #(
  parameter int NUM_TASKS = 3,
  parameter int TIDX_BITS = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pts_pkg::status_t     stat,
  output pts_pkg::cmd_t        cmd,
  output logic [TIDX_BITS-1:0] idx
);
  import pts_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_COMMIT} state_t;

  localparam logic [TIDX_BITS-1:0] LAST_IDX = TIDX_BITS'(NUM_TASKS - 1);

  state_t state;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.start      = in_valid && in_ready;
    cmd.scan       = (state == ST_SCAN);
    cmd.scan_first = (state == ST_SCAN) && (idx == '0);
    cmd.commit     = (state == ST_COMMIT) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          idx <= '0;
          if (in_valid) state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (idx == LAST_IDX) begin
            state <= ST_COMMIT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_COMMIT: begin
          if (stat.out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `PTS_ASSERT(a_start_scans, cmd.start |=> (state == ST_SCAN && idx == '0), "scan did not start")
  `PTS_NEVER(a_idx_range, state == ST_SCAN && idx > LAST_IDX, "scan index past last task")
  `PTS_ASSERT(a_commit_once, cmd.commit |=> (state == ST_IDLE && !cmd.commit), "commit repeated")

endmodule

FILE: rtl/pts_dpath.sv
module pts_dpath #(
  parameter int NUM_TASKS = 3,
  parameter int WORK_BITS = 10,
  parameter int TIDX_BITS = 2
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               restart,
  input  pts_pkg::cmd_t                      cmd,
  input  logic [TIDX_BITS-1:0]               idx,
  output pts_pkg::status_t                   stat,
  input  logic                               cfg_valid,
  input  logic [pts_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [pts_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pts_pkg::ID_BITS-1:0]        out_id,
  output logic [pts_pkg::TICK_BITS-1:0]      out_tick
);
  import pts_pkg::*;

  localparam int NCFG      = (NUM_TASKS < NUM_CFG_TASKS) ? NUM_TASKS : NUM_CFG_TASKS;
  localparam int CIDX_BITS = (NCFG > 1) ? $clog2(NCFG) : 1;

  logic                   policy_q;
  logic [CFG_DATA_BITS-1:0] burst_q  [NCFG];
  logic [PERIOD_BITS-1:0] period_q [NCFG];

  logic [WORK_BITS-1:0]   work_q   [NUM_TASKS];
  logic [PERIOD_BITS-1:0] phase_q  [NUM_TASKS];
  logic [TICK_BITS-1:0]   tick_q;

  logic                   best_valid;
  logic [PERIOD_BITS-1:0] best_key;
  logic [TIDX_BITS-1:0]   winner_q;

  logic [WORK_BITS-1:0]   task_burst [NUM_TASKS];
  logic [PERIOD_BITS-1:0] task_eff   [NUM_TASKS];
  logic [PERIOD_BITS-1:0] phase_next [NUM_TASKS];

  // Tasks without registers keep burst 0 and period 1.
  for (genvar t = 0; t < NUM_TASKS; t++) begin : g_task
    logic [PERIOD_BITS:0] inc;
    if (t < NCFG) begin : g_cfg
      assign task_burst[t] = WORK_BITS'(burst_q[t]);
      assign task_eff[t]   = (period_q[t] == '0) ? PERIOD_BITS'(1) : period_q[t];
    end else begin : g_fixed
      assign task_burst[t] = '0;
      assign task_eff[t]   = PERIOD_BITS'(1);
    end
    assign inc           = {1'b0, phase_q[t]} + 1'b1;
    assign phase_next[t] = (inc >= {1'b0, task_eff[t]}) ? '0 : inc[PERIOD_BITS-1:0];
  end

  // Scan of the task under idx: release, then key and compare.
  logic [PERIOD_BITS-1:0] cur_phase, cur_eff, rel_dl, key;
  logic [WORK_BITS-1:0]   cur_work;
  logic                   ready_task, take;

  always_comb begin
    cur_phase  = phase_q[idx];
    cur_eff    = task_eff[idx];
    cur_work   = (cur_phase == '0) ? task_burst[idx] : work_q[idx];
    rel_dl     = (cur_phase >= cur_eff) ? '0 : cur_eff - cur_phase;
    key        = policy_q ? rel_dl : cur_eff;
    ready_task = (cur_work != '0);
    take       = ready_task && (cmd.scan_first || !best_valid || key < best_key);
  end

  logic [TIDX_BITS:0]       id_sum;
  logic [CFG_IDX_BITS-1:0]  cfg_off;

  assign id_sum        = {1'b0, winner_q} + 1'b1;
  assign stat.out_free = !out_valid || out_ready;

  // task offset of a burst or period register index
  always_comb begin
    cfg_off = '0;
    if (cfg_index inside {[REG_BURST0:REG_BURST2]}) begin
      cfg_off = cfg_index - CFG_IDX_BITS'(REG_BURST0);
    end else if (cfg_index inside {[REG_PERIOD0:REG_PERIOD2]}) begin
      cfg_off = cfg_index - CFG_IDX_BITS'(REG_PERIOD0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_q  <= 1'b0;
      for (int t = 0; t < NCFG; t++) begin
        burst_q[t]  <= '0;
        period_q[t] <= PERIOD_BITS'(1);
      end
      for (int t = 0; t < NUM_TASKS; t++) begin
        work_q[t]  <= '0;
        phase_q[t] <= '0;
      end
      tick_q     <= '0;
      best_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_POLICY) begin
          policy_q <= cfg_data[0];
        end else if (cfg_index inside {[REG_BURST0:REG_BURST2]}) begin
          if (cfg_off < CFG_IDX_BITS'(NCFG)) burst_q[cfg_off[CIDX_BITS-1:0]] <= cfg_data;
        end else if (cfg_index inside {[REG_PERIOD0:REG_PERIOD2]}) begin
          if (cfg_off < CFG_IDX_BITS'(NCFG)) period_q[cfg_off[CIDX_BITS-1:0]] <= cfg_data;
        end
      end

      for (int t = 0; t < NUM_TASKS; t++) begin
        if (cmd.start && restart) begin
          work_q[t]  <= '0;
          phase_q[t] <= '0;
        end else if (cmd.scan && idx == TIDX_BITS'(t)) begin
          work_q[t] <= cur_work;
        end else if (cmd.commit) begin
          phase_q[t] <= phase_next[t];
          if (best_valid && winner_q == TIDX_BITS'(t)) work_q[t] <= work_q[t] - 1'b1;
        end
      end

      if (cmd.start && restart) begin
        tick_q <= '0;
      end else if (cmd.commit) begin
        tick_q <= tick_q + 1'b1;
      end

      if (cmd.scan) begin
        best_valid <= cmd.scan_first ? ready_task : (best_valid || ready_task);
        if (take) begin
          best_key <= key;
          winner_q <= idx;
        end
      end

      if (cmd.commit) begin
        out_valid <= 1'b1;
        out_id    <= best_valid ? id_sum[ID_BITS-1:0] : '0;
        out_tick  <= tick_q;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/periodic_task_scheduler_top.sv
// Periodic task scheduler, rate monotonic or earliest deadline first.
// Each tick word is accepted in idle, then scanned one task at a time in the serial
// key compare, then committed once the output is free; the result is registered at commit.
// A new word is accepted only after the previous word has committed.
// Synchronous active-high reset clears work, phases, tick count and output valid;
// policy resets to rate monotonic, bursts to 0, periods to 1.
module periodic_task_scheduler_top #(
  parameter int NUM_TASKS = 3,
  parameter int WORK_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [pts_pkg::IN_TDATA_BITS-1:0]   s_tdata,   // [0] restart
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [pts_pkg::OUT_TDATA_BITS-1:0]  m_tdata,   // [1:0] task_id, [17:2] tick_count
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pts_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [pts_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import pts_pkg::*;

  localparam int TIDX_BITS = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int PAD_BITS  = OUT_TDATA_BITS - ID_BITS - TICK_BITS;

  cmd_t                 cmd;
  status_t              stat;
  logic [TIDX_BITS-1:0] idx;
  logic [ID_BITS-1:0]   out_id;
  logic [TICK_BITS-1:0] out_tick;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {{PAD_BITS{1'b0}}, out_tick, out_id};

  pts_ctrl #(
    .NUM_TASKS (NUM_TASKS),
    .TIDX_BITS (TIDX_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd),
    .idx      (idx)
  );

  pts_dpath #(
    .NUM_TASKS (NUM_TASKS),
    .WORK_BITS (WORK_BITS),
    .TIDX_BITS (TIDX_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .restart   (s_tdata[0]),
    .cmd       (cmd),
    .idx       (idx),
    .stat      (stat),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_id    (out_id),
    .out_tick  (out_tick)
  );

endmodule
